>>> src/trq_pkg.sv
package trq_pkg;

  localparam int unsigned TOPICS   = 4;
  localparam int unsigned CAPACITY = 8;
  localparam int unsigned SLOTS    = TOPICS * CAPACITY;

  localparam int unsigned TopicW  = 2;
  localparam int unsigned ActiveW = 3;
  localparam int unsigned PtrW    = $clog2(CAPACITY);
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW   = $clog2(SLOTS);
  localparam int unsigned PaddrW  = 3;

  localparam logic [ActiveW-1:0] TopicsReset = ActiveW'(3);
  localparam logic [31:0]        AgeReset    = 32'd1000000;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_GET  = 2'd1,
    FUNC_DEQ  = 2'd2,
    FUNC_TICK = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_LATER = 2'd2
  } status_e;

  typedef enum logic {
    REG_TOPICS = 1'b0,
    REG_AGE    = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DEQ
  } state_e;

  typedef struct packed {
    logic [31:0] number;
    logic [31:0] stamp;
    logic [7:0]  pub;
    logic [31:0] payload;
  } slot_t;

  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] base,
                                              input logic [PtrW-1:0] off);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PtrW + 1)'(CAPACITY)) begin
      sum = sum - (PtrW + 1)'(CAPACITY);
    end
    return sum[PtrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [TopicW-1:0] topic,
                                                 input logic [PtrW-1:0] ptr);
    return AddrW'(int'(topic) * CAPACITY + int'(ptr));
  endfunction

endpackage

>>> src/trq_if.sv
interface trq_req_if;
  logic                          valid;
  logic                          ready;
  trq_pkg::func_e                func;
  logic [trq_pkg::TopicW-1:0]    topic;
  logic [31:0]                   last_seen;
  logic [7:0]                    pub_id;
  logic [31:0]                   payload;

  modport source (output valid, func, topic, last_seen, pub_id, payload, input ready);
  modport sink   (input valid, func, topic, last_seen, pub_id, payload, output ready);
endinterface

interface trq_rsp_if;
  logic             valid;
  logic             ready;
  trq_pkg::status_e status;
  logic [31:0]      entry_number;
  logic [7:0]       entry_pub;
  logic [31:0]      entry_payload;
  logic [31:0]      entry_stamp;

  modport source (output valid, status, entry_number, entry_pub, entry_payload, entry_stamp,
                  input ready);
  modport sink   (input valid, status, entry_number, entry_pub, entry_payload, entry_stamp,
                  output ready);
endinterface

>>> src/trq_ram.sv
module trq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/topic_ring_queue_engine.sv
// A tick, enqueue, failed request or request on an empty ring loads its result from S_EXEC;
// a dequeue on a non-empty ring reads the oldest entry in S_EXEC and decides on it in S_DEQ; a get
// reads the oldest entry in S_EXEC and then compares stored entries in S_SCAN until it decides.
// One request is taken at a time, and the next only once the current one is finished; a get
// walks the single read port of the slot memory one entry per cycle.
// Reset (rst_ni low, asynchronous) empties every ring, sets the sequence number to one,
// the time to zero and the registers to their defaults; the slot memory is not cleared.
module topic_ring_queue_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trq_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  trq_req_if.sink                     req_i,
  trq_rsp_if.source                   rsp_o
);
  import trq_pkg::*;

  // Configuration registers. Register index is the word address.
  logic [ActiveW-1:0] topics_q;
  logic [31:0]        age_limit_q;
  reg_e               reg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topics_q    <= TopicsReset;
      age_limit_q <= AgeReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TOPICS: topics_q    <= pwdata[ActiveW-1:0];
        REG_AGE:    age_limit_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOPICS: prdata = {{(32 - ActiveW){1'b0}}, topics_q};
      REG_AGE:    prdata = age_limit_q;
    endcase
  end

  // Control state: sequencer, ring heads and fill counts, global number and time.
  state_e             state_q, state_d;
  logic [PtrW-1:0]    head_q [TOPICS];
  logic [PtrW-1:0]    head_d [TOPICS];
  logic [CntW-1:0]    cnt_q  [TOPICS];
  logic [CntW-1:0]    cnt_d  [TOPICS];
  logic [CntW-1:0]    idx_q, idx_d;
  logic [31:0]        next_num_q, next_num_d;
  logic [31:0]        now_q, now_d;

  // The request is held for the whole of its processing.
  func_e              func_q;
  logic [TopicW-1:0]  topic_q;
  logic [31:0]        target_q;
  logic [7:0]         pub_q;
  logic [31:0]        payload_q;

  // Result register; a finished result may wait here while the next request is taken.
  logic               out_valid_q;
  status_e            out_status_q, out_status_d;
  slot_t              out_slot_q, out_slot_d;
  logic               out_load;
  logic               out_free;

  // Slot memory ports.
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  slot_t              ram_wdata, ram_rdata;

  logic               accept;
  logic               topic_ok;
  logic [PtrW-1:0]    cur_head;
  logic [CntW-1:0]    cur_cnt;
  logic               hit, later;
  logic [31:0]        age;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign topic_ok = (ActiveW'(topic_q) < topics_q) && (int'(topic_q) < TOPICS);
  assign cur_head = head_q[topic_q];
  assign cur_cnt  = cnt_q[topic_q];
  assign hit      = (ram_rdata.number == target_q);
  assign later    = (ram_rdata.number > target_q);
  assign age      = now_q - ram_rdata.stamp;

  trq_ram #(
    .Width ($bits(slot_t)),
    .Depth (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= req_i.func;
      topic_q   <= req_i.topic;
      target_q  <= req_i.last_seen + 32'd1;
      pub_q     <= req_i.pub_id;
      payload_q <= req_i.payload;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      next_num_q  <= 32'd1;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < TOPICS; t++) begin
        head_q[t] <= '0;
        cnt_q[t]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      next_num_q <= next_num_d;
      now_q      <= now_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sequencer. Every state that produces a result waits for the result register to be free;
  // a get that is waiting holds its memory read data by not issuing a new read.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    next_num_d   = next_num_q;
    now_d        = now_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    out_load     = 1'b0;
    out_status_d = ST_NONE;
    out_slot_d   = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = slot_addr(topic_q, ptr_add(cur_head, cur_cnt[PtrW-1:0]));
    ram_raddr    = slot_addr(topic_q, ptr_add(cur_head, idx_q[PtrW-1:0]));
    ram_wdata    = '{number: next_num_q, stamp: now_q, pub: pub_q, payload: payload_q};

    unique case (state_q)
      S_IDLE: begin
        // The first read of the next request starts from the oldest entry.
        idx_d = '0;
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        idx_d = '0;
        if (func_q == FUNC_TICK) begin
          if (out_free) begin
            now_d              = now_q + 32'd1;
            out_load           = 1'b1;
            out_status_d       = ST_DONE;
            out_slot_d.stamp   = now_q + 32'd1;
            state_d            = S_IDLE;
          end
        end else if (!topic_ok) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          unique case (func_q)
            FUNC_ENQ: begin
              if (out_free) begin
                out_load = 1'b1;
                state_d  = S_IDLE;
                if (int'(cur_cnt) < CAPACITY) begin
                  ram_we         = 1'b1;
                  out_status_d   = ST_DONE;
                  out_slot_d     = ram_wdata;
                  next_num_d     = next_num_q + 32'd1;
                  cnt_d[topic_q] = cur_cnt + CntW'(1);
                end
              end
            end
            FUNC_GET: begin
              if (cur_cnt == '0) begin
                if (out_free) begin
                  out_load = 1'b1;
                  state_d  = S_IDLE;
                end
              end else begin
                // Read the oldest entry; the scan compares it next cycle.
                ram_re  = 1'b1;
                idx_d   = CntW'(1);
                state_d = S_SCAN;
              end
            end
            FUNC_DEQ: begin
              if (cur_cnt == '0) begin
                if (out_free) begin
                  out_load = 1'b1;
                  state_d  = S_IDLE;
                end
              end else begin
                ram_re  = 1'b1;
                state_d = S_DEQ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // ram_rdata holds entry idx_q - 1; idx_q entries have been read so far.
        if (hit || later) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = hit ? ST_DONE : ST_LATER;
            out_slot_d   = ram_rdata;
            state_d      = S_IDLE;
          end
        end else if (idx_q == cur_cnt) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_q + CntW'(1);
        end
      end

      S_DEQ: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (age >= age_limit_q) begin
            out_status_d    = ST_DONE;
            out_slot_d      = ram_rdata;
            head_d[topic_q] = ptr_add(cur_head, PtrW'(1));
            cnt_d[topic_q]  = cur_cnt - CntW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.entry_number  = out_slot_q.number;
  assign rsp_o.entry_pub     = out_slot_q.pub;
  assign rsp_o.entry_payload = out_slot_q.payload;
  assign rsp_o.entry_stamp   = out_slot_q.stamp;

endmodule

>>> src/trq_checker.sv
module trq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_number,
  input logic [7:0]  out_pub,
  input logic [31:0] out_payload,
  input logic [31:0] out_stamp
);
  import trq_pkg::*;

  // One request is processed at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  // A result that was not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> ($stable(out_status) && $stable(out_number)
                                   && $stable(out_payload) && $stable(out_stamp)))
    else $error("result changed while stalled");

  // A failed or empty result carries no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status == ST_NONE) |->
      (out_number == '0 && out_pub == '0 && out_payload == '0 && out_stamp == '0))
    else $error("failed result carries entry data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status == ST_NONE || out_status == ST_DONE
                   || out_status == ST_LATER))
    else $error("undefined result status");

endmodule

bind topic_ring_queue_engine trq_checker u_trq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (req_i.valid),
  .in_ready    (req_i.ready),
  .out_valid   (rsp_o.valid),
  .out_ready   (rsp_o.ready),
  .out_status  (rsp_o.status),
  .out_number  (rsp_o.entry_number),
  .out_pub     (rsp_o.entry_pub),
  .out_payload (rsp_o.entry_payload),
  .out_stamp   (rsp_o.entry_stamp)
);
